// ----- hdl/olsb_pkg.sv -----
`default_nettype none
package olsb_pkg;

    localparam int COORD_W = 13;
    localparam int POS_W   = 12;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int N_CH    = 3;
    localparam int NUM_W   = 20;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_RIGHT  = 3'd2,
        REG_BOTTOM = 3'd3
    } cfg_reg_t;

    // pixel taken when no blend is needed, plus flags
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             in_overlap;
        logic             blend;
    } side_t;

    typedef struct packed {
        logic [N_CH-1:0][NUM_W-1:0] rem;
        logic [N_CH-1:0][CH_W-1:0]  quot;
        logic [NUM_W-1:0]           dsh;
        side_t                      side;
    } div_t;

endpackage
`default_nettype wire

// ----- hdl/olsb_div_stage.sv -----
`default_nettype none
// Two quotient bits per channel per stage, restoring form with a shifting divisor.
module olsb_div_stage (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire olsb_pkg::div_t in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output olsb_pkg::div_t      out_data
);

    logic             valid_reg;
    olsb_pkg::div_t   data_reg;
    olsb_pkg::div_t   data_next;

    logic [olsb_pkg::N_CH-1:0][olsb_pkg::NUM_W-1:0] r1;
    logic [olsb_pkg::N_CH-1:0][olsb_pkg::NUM_W-1:0] r2;
    logic [olsb_pkg::N_CH-1:0]                      b1;
    logic [olsb_pkg::N_CH-1:0]                      b0;
    logic [olsb_pkg::NUM_W-1:0]                     d1;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        d1 = in_data.dsh >> 1;
        data_next = in_data;
        for (int c = 0; c < olsb_pkg::N_CH; c++) begin
            b1[c] = in_data.rem[c] >= in_data.dsh;
            r1[c] = b1[c] ? in_data.rem[c] - in_data.dsh : in_data.rem[c];
            b0[c] = r1[c] >= d1;
            r2[c] = b0[c] ? r1[c] - d1 : r1[c];
            data_next.rem[c]  = r2[c];
            data_next.quot[c] = {in_data.quot[c][olsb_pkg::CH_W-3:0], b1[c], b0[c]};
        end
        data_next.dsh = in_data.dsh >> 2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ----- hdl/overlap_linear_seam_blend_core.sv -----
`default_nettype none
// Channel  Dir  Handshake             Payload
// s_       in   s_tvalid/s_tready     col, row, reference, warped, current pixel
// m_       out  m_tvalid/m_tready     blended pixel (tdata), in_overlap (tuser)
// cfg_     in   cfg_valid/cfg_ready   register index, 13-bit value
//
// One pixel per clock while m_tready is held high; stages are region check,
// weight multiply, four radix-4 divider stages and the output register.
// Each stage holds its own valid bit and fills bubbles, so a stalled output
// holds data in place; nothing is dropped or repeated.
// Synchronous active-low reset clears valid bits and the region registers.
module overlap_linear_seam_blend_core #(
    parameter int MAX_IMAGE_DIM = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [11:0] pixel_col, [23:12] pixel_row, [47:24] reference_pixel,
    // [71:48] warped_pixel, [95:72] current_pixel
    input  wire  [95:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [23:0] blended_pixel
    output logic [23:0] m_tdata,
    // [0] in_overlap
    output logic [0:0]  m_tuser,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [olsb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [olsb_pkg::COORD_W-1:0]   cfg_data
);

    localparam int CW = olsb_pkg::COORD_W;
    localparam int PW = olsb_pkg::PIX_W;
    localparam int HW = olsb_pkg::CH_W;
    localparam int NW = olsb_pkg::NUM_W;
    localparam int NC = olsb_pkg::N_CH;
    localparam int NSTAGE = 4;

    // ---------------- configuration ----------------
    logic [CW-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [CW-1:0] cfg_sat;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (32'(cfg_data) > MAX_IMAGE_DIM) begin
            cfg_sat = CW'(MAX_IMAGE_DIM);
        end else begin
            cfg_sat = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                olsb_pkg::REG_LEFT:   left_reg   <= cfg_sat;
                olsb_pkg::REG_TOP:    top_reg    <= cfg_sat;
                olsb_pkg::REG_RIGHT:  right_reg  <= cfg_sat;
                olsb_pkg::REG_BOTTOM: bottom_reg <= cfg_sat;
                default: ;
            endcase
        end
    end

    // ---------------- handshake chain ----------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic en1, en2, en_out;
    logic [NSTAGE:0] dv_valid;
    logic [NSTAGE:0] dv_ready;
    olsb_pkg::div_t  dv_data [NSTAGE+1];

    assign en_out   = !out_valid_reg || m_tready;
    assign en2      = !s2_valid_reg || dv_ready[0];
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;

    // ---------------- stage 1: region check and weights ----------------
    logic [CW-1:0] col_in, row_in;
    logic [PW-1:0] ref_in, warp_in, cur_in;
    logic          inside_in;

    assign col_in  = {1'b0, s_tdata[11:0]};
    assign row_in  = {1'b0, s_tdata[23:12]};
    assign ref_in  = s_tdata[47:24];
    assign warp_in = s_tdata[71:48];
    assign cur_in  = s_tdata[95:72];

    assign inside_in = (right_reg > left_reg) && (col_in >= left_reg) &&
                       (col_in < right_reg) && (row_in >= top_reg) &&
                       (row_in < bottom_reg);

    logic [PW-1:0]   s1_ref_reg, s1_warp_reg;
    logic [CW-1:0]   s1_wr_reg, s1_ww_reg, s1_den_reg;
    olsb_pkg::side_t s1_side_reg;
    olsb_pkg::side_t s1_side_next;

    always_comb begin
        s1_side_next.in_overlap = inside_in;
        s1_side_next.blend      = 1'b0;
        if (!inside_in) begin
            s1_side_next.pix = cur_in;
        end else if (warp_in == '0) begin
            s1_side_next.pix = ref_in;
        end else if (ref_in == '0) begin
            s1_side_next.pix = warp_in;
        end else begin
            s1_side_next.pix   = cur_in;
            s1_side_next.blend = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en1) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            s1_ref_reg  <= ref_in;
            s1_warp_reg <= warp_in;
            s1_wr_reg   <= right_reg - col_in;
            s1_ww_reg   <= col_in - left_reg;
            s1_den_reg  <= right_reg - left_reg;
            s1_side_reg <= s1_side_next;
        end
    end

    // ---------------- stage 2: weighted sums ----------------
    logic [NC-1:0][NW:0] prod_r, prod_w, sum_rw;
    olsb_pkg::div_t      s2_data_reg;
    olsb_pkg::div_t      s2_data_next;

    always_comb begin
        s2_data_next = '0;
        for (int c = 0; c < NC; c++) begin
            prod_r[c] = {{(NW+1-HW){1'b0}}, s1_ref_reg[c*HW +: HW]} *
                        {{(NW+1-CW){1'b0}}, s1_wr_reg};
            prod_w[c] = {{(NW+1-HW){1'b0}}, s1_warp_reg[c*HW +: HW]} *
                        {{(NW+1-CW){1'b0}}, s1_ww_reg};
            sum_rw[c] = prod_r[c] + prod_w[c];
            s2_data_next.rem[c] = sum_rw[c][NW-1:0];
        end
        // quotient fits in one byte: start with the divisor at bit 7
        s2_data_next.dsh  = {s1_den_reg, {(NW-CW){1'b0}}};
        s2_data_next.side = s1_side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && s1_valid_reg) begin
            s2_data_reg <= s2_data_next;
        end
    end

    // ---------------- divider stages ----------------
    assign dv_valid[0] = s2_valid_reg;
    assign dv_data[0]  = s2_data_reg;
    assign dv_ready[NSTAGE] = en_out;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_div
        olsb_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[g]),
            .in_ready  (dv_ready[g]),
            .in_data   (dv_data[g]),
            .out_valid (dv_valid[g+1]),
            .out_ready (dv_ready[g+1]),
            .out_data  (dv_data[g+1])
        );
    end

    // ---------------- output register ----------------
    logic [PW-1:0] out_pix_reg;
    logic          out_ovl_reg;
    logic [PW-1:0] out_pix_next;

    always_comb begin
        if (dv_data[NSTAGE].side.blend) begin
            out_pix_next = dv_data[NSTAGE].quot;
        end else begin
            out_pix_next = dv_data[NSTAGE].side.pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en_out) begin
            out_valid_reg <= dv_valid[NSTAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && dv_valid[NSTAGE]) begin
            out_pix_reg <= out_pix_next;
            out_ovl_reg <= dv_data[NSTAGE].side.in_overlap;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_pix_reg;
    assign m_tuser[0] = out_ovl_reg;

endmodule
`default_nettype wire

// ----- test/overlap_linear_seam_blend_core_test.sv -----
`timescale 1ns / 1ps
module overlap_linear_seam_blend_core_test;

    localparam int          MAX_DIM         = 4096;
    localparam int          LATENCY         = 7;
    localparam int          MAX_IDLE        = 17;
    localparam int          LONG_HOLD       = 400;
    localparam int          RAND_PHASES     = 10;
    localparam int          ITEMS_PER_PHASE = 55;
    localparam int          HOLD_PHASE      = 2;
    localparam longint      TIMEOUT_NS      = 4_000_000;
    // index past the last region register; the block must ignore it
    localparam logic [olsb_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic [olsb_pkg::PIX_W-1:0] pix;
        logic                       ovl;
    } canvas_pixel_t;

    // keeps a copy of the region registers and the blended pixels still due
    class blend_scoreboard;
        int unsigned   left, top, right, bottom;
        int unsigned   checked;
        canvas_pixel_t due_q[$];

        function new();
            left = 0; top = 0; right = 0; bottom = 0; checked = 0;
        endfunction

        function void set_reg(logic [olsb_pkg::CFG_IDX_W-1:0] idx,
                              logic [olsb_pkg::COORD_W-1:0] val);
            int unsigned v;
            v = (val > MAX_DIM) ? MAX_DIM : val;
            case (idx)
                olsb_pkg::REG_LEFT:   left = v;
                olsb_pkg::REG_TOP:    top = v;
                olsb_pkg::REG_RIGHT:  right = v;
                olsb_pkg::REG_BOTTOM: bottom = v;
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [95:0] d);
            int unsigned                col, row, wr, ww, den, c;
            logic [olsb_pkg::PIX_W-1:0] refp, warp, cur, res;
            bit                         in_region;
            canvas_pixel_t              e;
            col  = d[11:0];
            row  = d[23:12];
            refp = d[47:24];
            warp = d[71:48];
            cur  = d[95:72];
            in_region = right > left && col >= left && col < right &&
                        row >= top && row < bottom;
            if (!in_region) begin
                res = cur;
            end else if (warp == 0) begin
                res = refp;
            end else if (refp == 0) begin
                res = warp;
            end else begin
                den = right - left;
                wr  = right - col;
                ww  = col - left;
                for (int ch = 0; ch < olsb_pkg::N_CH; ch++) begin
                    c = (refp[ch*olsb_pkg::CH_W +: olsb_pkg::CH_W] * wr +
                         warp[ch*olsb_pkg::CH_W +: olsb_pkg::CH_W] * ww) / den;
                    res[ch*olsb_pkg::CH_W +: olsb_pkg::CH_W] = c[olsb_pkg::CH_W-1:0];
                end
            end
            e.pix = res;
            e.ovl = in_region;
            due_q = {due_q, e};
        endfunction

        function bit check_result(logic [olsb_pkg::PIX_W-1:0] pix, logic ovl,
                                  output string why);
            canvas_pixel_t e;
            bit            ok;
            if (due_q.size() == 0) begin
                why = $sformatf("result %06h overlap %0b with nothing pending", pix, ovl);
                return 0;
            end
            e  = due_q.pop_front();
            ok = 1;
            why = $sformatf("result %0d:", checked);
            if (pix !== e.pix) begin
                why = {why, $sformatf(" blended_pixel %06h want %06h", pix, e.pix)};
                ok = 0;
            end
            if (ovl !== e.ovl) begin
                why = {why, $sformatf(" in_overlap %0b want %0b", ovl, e.ovl)};
                ok = 0;
            end
            checked++;
            return ok;
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [95:0]                    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [23:0]                    m_tdata;
    logic [0:0]                     m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [olsb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [olsb_pkg::COORD_W-1:0]   cfg_data;

    blend_scoreboard sb = new();
    int  error_count   = 0;
    int  pixels_sent   = 0;
    int  region_count  = 0;
    bit  tx_no_gap     = 0;
    bit  rx_no_stall   = 0;
    bit  hold_request  = 0;
    bit  hold_done     = 0;

    overlap_linear_seam_blend_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string why);
        $display("MISMATCH at %0t: %s", $realtime, why);
        error_count++;
    endtask

    task automatic send_pixel(input int unsigned col, input int unsigned row,
                              input logic [23:0] refp, input logic [23:0] warp,
                              input logic [23:0] cur);
        int unsigned gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cur, warp, refp, row[11:0], col[11:0]};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(s_tdata);
        pixels_sent++;
    endtask

    // drain the pipe before touching the region registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [olsb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [olsb_pkg::COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic set_region(input logic [olsb_pkg::COORD_W-1:0] l,
                              input logic [olsb_pkg::COORD_W-1:0] t,
                              input logic [olsb_pkg::COORD_W-1:0] r,
                              input logic [olsb_pkg::COORD_W-1:0] b);
        drain();
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, olsb_pkg::COORD_W'($urandom_range(0, 8191)));
        write_reg(olsb_pkg::REG_LEFT, l);
        write_reg(olsb_pkg::REG_TOP, t);
        write_reg(olsb_pkg::REG_RIGHT, r);
        write_reg(olsb_pkg::REG_BOTTOM, b);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        region_count++;
    endtask

    function automatic logic [23:0] random_source();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 24'h000000;
        else if (k == 1)
            return 24'hFFFFFF;
        return 24'($urandom());
    endfunction

    // pick a coordinate around [lo, hi) most of the time
    function automatic int unsigned near_span(int unsigned lo, int unsigned hi);
        int unsigned a, z;
        if ($urandom_range(0, 9) < 3)
            return $urandom_range(0, MAX_DIM - 1);
        a = (lo > 2) ? lo - 2 : 0;
        z = (hi + 1 < MAX_DIM) ? hi + 1 : MAX_DIM - 1;
        if (a > z)
            return $urandom_range(0, MAX_DIM - 1);
        return $urandom_range(a, z);
    endfunction

    task automatic random_region();
        int unsigned k, l, t, r, b;
        k = $urandom_range(0, 9);
        case (k)
            0: begin
                l = 0; t = 0; r = MAX_DIM; b = MAX_DIM;
            end
            1: begin
                // values past the canvas saturate
                l = $urandom_range(0, 4000); t = $urandom_range(0, 4000);
                r = $urandom_range(MAX_DIM + 1, 8191); b = $urandom_range(MAX_DIM + 1, 8191);
            end
            2: begin
                r = $urandom_range(0, 4000); l = $urandom_range(r, 8191);
                t = $urandom_range(0, 4000); b = $urandom_range(t + 1, MAX_DIM);
            end
            3: begin
                l = $urandom_range(0, MAX_DIM - 1); r = l + 1;
                t = $urandom_range(0, 4000); b = $urandom_range(t + 1, MAX_DIM);
            end
            default: begin
                l = $urandom_range(0, 3000); r = $urandom_range(l + 1, MAX_DIM);
                t = $urandom_range(0, 3000); b = $urandom_range(t + 1, MAX_DIM);
            end
        endcase
        set_region(olsb_pkg::COORD_W'(l), olsb_pkg::COORD_W'(t),
                   olsb_pkg::COORD_W'(r), olsb_pkg::COORD_W'(b));
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = olsb_pkg::REG_LEFT;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset: empty region, everything passes through
        tx_no_gap = $urandom_range(0, 1);
        send_pixel(0, 0, 24'h123456, 24'h654321, 24'hABCDEF);
        send_pixel(4095, 4095, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(0, 0, 24'h000000, 24'h000000, 24'h5A5A5A);

        // whole canvas
        set_region(0, 0, MAX_DIM, MAX_DIM);
        send_pixel(0, 0, 24'h102030, 24'hF0E0D0, 24'h777777);
        send_pixel(4095, 0, 24'h102030, 24'hF0E0D0, 24'h777777);
        send_pixel(2048, 4095, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
        send_pixel(1000, 1000, 24'h3C4D5E, 24'h000000, 24'h111111);
        send_pixel(1000, 1000, 24'h000000, 24'h3C4D5E, 24'h111111);
        send_pixel(1000, 1000, 24'h000000, 24'h000000, 24'h111111);
        send_pixel(3001, 17, 24'hFF00FF, 24'h00FF00, 24'h222222);

        // one column wide at the right edge
        set_region(4095, 0, MAX_DIM, MAX_DIM);
        send_pixel(4095, 200, 24'h808080, 24'h010101, 24'h333333);
        send_pixel(4094, 200, 24'h808080, 24'h010101, 24'h333333);

        // right and bottom past the canvas, last row only
        set_region(100, 4095, 8191, 8191);
        send_pixel(4095, 4095, 24'hC0FFEE, 24'h0BADF0, 24'h444444);
        send_pixel(4095, 4094, 24'hC0FFEE, 24'h0BADF0, 24'h444444);
        send_pixel(99, 4095, 24'hC0FFEE, 24'h0BADF0, 24'h444444);
        send_pixel(100, 4095, 24'hC0FFEE, 24'h0BADF0, 24'h444444);

        // inverted columns
        set_region(200, 10, 100, 20);
        send_pixel(150, 15, 24'h999999, 24'h888888, 24'h555555);
        send_pixel(200, 10, 24'h999999, 24'h888888, 24'h555555);

        // left saturates onto right: zero width
        set_region(8191, 0, 8191, MAX_DIM);
        send_pixel(4095, 0, 24'hABABAB, 24'hCDCDCD, 24'h666666);

        set_region(10, 20, 10, 30);
        send_pixel(10, 25, 24'hABABAB, 24'hCDCDCD, 24'h676767);

        // rows empty, columns fine
        set_region(0, 0, MAX_DIM, 0);
        send_pixel(5, 0, 24'hABABAB, 24'hCDCDCD, 24'h686868);

        for (int p = 0; p < RAND_PHASES; p++) begin
            random_region();
            tx_no_gap   = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            if (p == HOLD_PHASE) begin
                tx_no_gap    = 1;
                hold_request = 1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_pixel(near_span(sb.left, sb.right), near_span(sb.top, sb.bottom),
                           random_source(), random_source(), 24'($urandom()));
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY * 4) @(posedge aclk);

        $display("Sent %0d pixels across %0d region settings; %0d results checked",
                 pixels_sent, region_count, sb.checked);
        $display("Long output stall exercised: %0b", hold_done);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random back-pressure, one long hold on request
    initial begin : result_sink
        int unsigned stall;
        string       why;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1;
            end
            stall = rx_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (!sb.check_result(m_tdata, m_tuser[0], why))
                report_mismatch(why);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still pending", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
